@@ design/mhpq_pkg.sv @@
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [4:0]         count;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FULL,
    OP_EMPTY,
    OP_INS_START,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_WR_HOLE,
    OP_RD_ROOT,
    OP_RD_LAST,
    OP_DN_START,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DN_MOVE
  } dp_op_e;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_gt;
    logic no_left;
    logic dn_move;
  } dp_sts_t;

endpackage

@@ design/mhpq_datapath.sv @@
// Heap RAM, count, hole position and compare logic of the max-heap queue.
module mhpq_datapath #(
  parameter int CAPACITY = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhpq_pkg::dp_op_e  op_i,
  input  mhpq_pkg::in_t     in_i,
  output mhpq_pkg::dp_sts_t sts_o,
  output mhpq_pkg::out_t    result_o
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [0:CAPACITY];

  logic signed [31:0] val_q, val_d;
  logic signed [31:0] lv_q, lv_d;
  logic signed [31:0] res_q, res_d;
  logic signed [31:0] rd_q;
  logic [1:0]         status_q, status_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      cnt_q, cnt_d;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;

  logic [AW:0]        lc, rc, cnt_ext;
  logic [AW-1:0]      parent;
  logic               has_right, l_gt, r_gt;
  logic signed [31:0] best_val;
  logic [AW-1:0]      best_idx;

  assign cnt_ext   = {1'b0, cnt_q};
  assign lc        = {pos_q, 1'b0};
  assign rc        = {pos_q, 1'b1};
  assign parent    = pos_q >> 1;
  assign has_right = (rc <= cnt_ext);

  assign l_gt     = (lv_q > val_q);
  assign r_gt     = has_right && (rd_q > (l_gt ? lv_q : val_q));
  assign best_val = r_gt ? rd_q : lv_q;
  assign best_idx = r_gt ? rc[AW-1:0] : lc[AW-1:0];

  assign sts_o.full    = (cnt_q >= AW'(CAPACITY));
  assign sts_o.empty   = (cnt_q == '0);
  assign sts_o.at_root = (pos_q == AW'(1));
  assign sts_o.up_gt   = (val_q > rd_q);
  assign sts_o.no_left = (lc > cnt_ext);
  assign sts_o.dn_move = l_gt || r_gt;

  always_comb begin
    val_d    = val_q;
    lv_d     = lv_q;
    res_d    = res_q;
    status_d = status_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = val_q;
    case (op_i)
      OP_ACCEPT: begin
        val_d    = in_i.value;
        res_d    = '0;
        status_d = STATUS_OK;
      end
      OP_FULL:  status_d = STATUS_FULL;
      OP_EMPTY: status_d = STATUS_EMPTY;
      OP_INS_START: begin
        cnt_d = cnt_q + AW'(1);
        pos_d = cnt_q + AW'(1);
      end
      OP_RD_PARENT: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      OP_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
        pos_d   = parent;
      end
      OP_WR_HOLE: wr_en = 1'b1;
      OP_RD_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      OP_RD_LAST: begin
        res_d   = rd_q;
        rd_en   = 1'b1;
        rd_addr = cnt_q;
      end
      OP_DN_START: begin
        val_d = rd_q;
        cnt_d = cnt_q - AW'(1);
        pos_d = AW'(1);
      end
      OP_RD_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = lc[AW-1:0];
      end
      OP_RD_RIGHT: begin
        lv_d    = rd_q;
        rd_en   = has_right;
        rd_addr = rc[AW-1:0];
      end
      OP_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = best_val;
        pos_d   = best_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    lv_q     <= lv_d;
    res_q    <= res_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  assign result_o.result_value = res_q;
  assign result_o.status       = status_q;
  assign result_o.count        = 5'(cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= AW'(CAPACITY))
    else $error("entry count above capacity");

  // extracting the last entry writes the dead root slot
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0) && ((wr_addr <= cnt_q) || (wr_addr == AW'(1))))
    else $error("heap write outside held entries");

  a_rd_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_addr != '0) && (rd_addr <= cnt_q))
    else $error("heap read outside held entries");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_INS_START) |=> (cnt_q == $past(cnt_q) + AW'(1)))
    else $error("insert did not advance count");

endmodule

@@ design/mhpq_ctrl.sv @@
// Sequencer for insert / sift-up and extract / sift-down transactions.
module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              mode_i,
  input  mhpq_pkg::dp_sts_t sts_i,
  output mhpq_pkg::dp_op_e  op_o,
  output logic              busy,
  output logic              done_o
);
  import mhpq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_IN_CHK  = 11'b000_0000_0010,
    S_UP_CHK  = 11'b000_0000_0100,
    S_UP_CMP  = 11'b000_0000_1000,
    S_EX_CHK  = 11'b000_0001_0000,
    S_EX_ROOT = 11'b000_0010_0000,
    S_EX_LAST = 11'b000_0100_0000,
    S_DN_CHK  = 11'b000_1000_0000,
    S_DN_L    = 11'b001_0000_0000,
    S_DN_CMP  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = OP_ACCEPT;
          state_d = (mode_i == MODE_EXTRACT) ? S_EX_CHK : S_IN_CHK;
        end
      end
      S_IN_CHK: begin
        if (sts_i.full) begin
          op_o    = OP_FULL;
          state_d = S_DONE;
        end else begin
          op_o    = OP_INS_START;
          state_d = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts_i.at_root) begin
          op_o    = OP_WR_HOLE;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD_PARENT;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_gt) begin
          op_o    = OP_UP_MOVE;
          state_d = S_UP_CHK;
        end else begin
          op_o    = OP_WR_HOLE;
          state_d = S_DONE;
        end
      end
      S_EX_CHK: begin
        if (sts_i.empty) begin
          op_o    = OP_EMPTY;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD_ROOT;
          state_d = S_EX_ROOT;
        end
      end
      S_EX_ROOT: begin
        op_o    = OP_RD_LAST;
        state_d = S_EX_LAST;
      end
      S_EX_LAST: begin
        op_o    = OP_DN_START;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts_i.no_left) begin
          op_o    = OP_WR_HOLE;
          state_d = S_DONE;
        end else begin
          op_o    = OP_RD_LEFT;
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        op_o    = OP_RD_RIGHT;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_move) begin
          op_o    = OP_DN_MOVE;
          state_d = S_DN_CHK;
        end else begin
          op_o    = OP_WR_HOLE;
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == OP_WR_HOLE) |=> done_o)
    else $error("hole write not followed by result");

endmodule

@@ design/max_heap_priority_queue_top.sv @@
// Top level of the binary max-heap priority queue.
//
//  channel   signals                    direction  handshake
//  command   start, in_i (mode, value)  in         accepted when start && !busy
//  result    done_o, result_o           out        one-cycle strobe, no backpressure
//
// A full insert or an empty extract goes straight to the result strobe. Otherwise an
// insert sifts up, reading the parent and moving it down per level, and an extract reads
// the root and last entry, then sifts down, reading the children of the hole per level.
// Busy drops the cycle after the strobe. Each step makes at most one heap RAM access
// through a single registered read port.
// Reset clears the count and the sequencer, not the RAM; the receiver cannot stall.
module max_heap_priority_queue_top #(
  parameter int CAPACITY = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  mhpq_pkg::in_t  in_i,
  output logic           busy,
  output logic           done_o,
  output mhpq_pkg::out_t result_o
);
  import mhpq_pkg::*;

  dp_op_e  op;
  dp_sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (in_i.mode),
    .sts_i  (sts),
    .op_o   (op),
    .busy   (busy),
    .done_o (done_o)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .in_i     (in_i),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

@@ bench/heap_checker.sv @@
// Checker for the max-heap queue: predicts each transaction's result and compares it.
`timescale 1ns / 100ps

module heap_checker #(
  parameter int HEAP_CAP = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  mhpq_pkg::in_t  cmd_i,
  input  logic           done_i,
  input  mhpq_pkg::out_t result_i,
  output int             fail_count_o,
  output int             pending_o
);
  import mhpq_pkg::*;

  logic signed [31:0] heap_mem [1:HEAP_CAP];
  int                 heap_len;
  out_t               expected_q [$];

  function automatic out_t heap_apply(in_t cmd);
    out_t               res;
    int                 pos;
    int                 lc;
    int                 rc;
    int                 best;
    logic signed [31:0] tmp;
    bit                 moving;
    res = '0;
    if (cmd.mode == MODE_INSERT) begin
      if (heap_len >= HEAP_CAP) begin
        res.status = STATUS_FULL;
      end else begin
        heap_len++;
        heap_mem[heap_len] = cmd.value;
        pos = heap_len;
        while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[pos / 2];
          heap_mem[pos / 2] = tmp;
          pos = pos / 2;
        end
      end
    end else begin
      if (heap_len == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.result_value = heap_mem[1];
        heap_mem[1] = heap_mem[heap_len];
        heap_len--;
        pos = 1;
        moving = 1'b1;
        while (moving) begin
          lc = 2 * pos;
          rc = lc + 1;
          best = pos;
          if (lc <= heap_len && heap_mem[lc] > heap_mem[best]) best = lc;
          if (rc <= heap_len && heap_mem[rc] > heap_mem[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            tmp = heap_mem[best];
            heap_mem[best] = heap_mem[pos];
            heap_mem[pos] = tmp;
            pos = best;
          end
        end
      end
    end
    res.count = heap_len[4:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      heap_len = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // result of the previous transaction is checked before a new one is queued
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction pending: value %0d status %0d count %0d",
                 result_i.result_value, result_i.status, result_i.count);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (result_i.result_value !== want.result_value) begin
            $error("result_value expected %0d actual %0d",
                   want.result_value, result_i.result_value);
            errs++;
          end
          if (result_i.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, result_i.status);
            errs++;
          end
          if (result_i.count !== want.count) begin
            $error("count expected %0d actual %0d", want.count, result_i.count);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(heap_apply(cmd_i));
      fail_count_o <= fail_count_o + errs;
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the max-heap queue: reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import mhpq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 90;
  localparam int SEG_COUNT   = 17;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  in_t   in_i = '0;
  logic  busy;
  logic  done_o;
  out_t  result_o;
  int    fail_count;
  int    pending;
  int    stall_cycles = 0;

  max_heap_priority_queue_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .in_i     (in_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  heap_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (in_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 7)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $signed($urandom >> $urandom_range(0, 31)) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
    return v;
  endfunction

  // one transaction; optional low burst on start afterwards
  task automatic issue(logic mode, logic signed [31:0] value, bit idle_on);
    @(negedge clk_i);
    start = 1'b1;
    in_i.mode = mode;
    in_i.value = value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (idle_on && $urandom_range(0, 1)) begin
      @(negedge clk_i);
      start = 1'b0;
      in_i.mode = 1'($urandom_range(0, 1));
      in_i.value = $urandom;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int ins_pct;
    bit idle_on;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty extract, extremes, ties, drain to empty
    issue(MODE_EXTRACT, 32'sh12345678, 1'b1);
    issue(MODE_INSERT, 0, 1'b1);
    issue(MODE_INSERT, 32'sh7fffffff, 1'b1);
    issue(MODE_INSERT, 32'sh80000000, 1'b1);
    issue(MODE_INSERT, -1, 1'b1);
    issue(MODE_INSERT, 1, 1'b1);
    issue(MODE_INSERT, 32'sh7fffffff, 1'b1);
    issue(MODE_INSERT, 32'sh80000000, 1'b1);
    repeat (3) issue(MODE_EXTRACT, $urandom, 1'b1);
    repeat (4) issue(MODE_INSERT, 5, 1'b1);
    repeat (9) issue(MODE_EXTRACT, $urandom, 1'b1);
    wait_drained();

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      idle_on = (seg < SEG_COUNT - 3);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if ($urandom_range(0, 99) < ins_pct) issue(MODE_INSERT, pick_value(), idle_on);
        else issue(MODE_EXTRACT, $urandom, idle_on);
      end
      if (seg % 4 == 3) wait_drained();
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
